@@ design/svm_pkg.sv @@
// Package with shared types and constants for the sample voice mixer.
`default_nettype none
package svm_pkg;

  localparam int SOUND_SLOTS  = 32;
  localparam int SLOT_W       = 5;
  localparam int SAMPLE_WORDS = 65536;
  localparam int ADDR_W       = 16;
  localparam int SAMPLE_BITS  = 16;
  localparam int POS_W        = 17;
  localparam int GAIN_W       = 20;
  localparam int DEF_VOICES   = 16;

  localparam logic [15:0] UNITY_Q15 = 16'd32768;

  typedef enum logic [2:0] {
    CMD_LOAD   = 3'd0,
    CMD_EXTENT = 3'd1,
    CMD_TRIG   = 3'd2,
    CMD_QUERY  = 3'd3,
    CMD_TICK   = 3'd4
  } cmd_t;

  typedef enum logic [2:0] {
    REG_MASTER = 3'd0,
    REG_EFFECT = 3'd1,
    REG_MUSIC  = 3'd2,
    REG_BSOUND = 3'd3,
    REG_BGAIN  = 3'd4,
    REG_INUSE  = 3'd5
  } reg_idx_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_GAIN,
    ST_BOOST,
    ST_VOICE,
    ST_DRAIN,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic              active;
    logic [SLOT_W-1:0] sound;
    logic [POS_W-1:0]  pos;
  } voice_t;

  typedef struct packed {
    logic busy;
    logic shift;
  } ctrl_t;

endpackage
`default_nettype wire

@@ design/svm_voice_cell.sv @@
// One voice cell of the rotating voice chain.
`default_nettype none
module svm_voice_cell (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            shift,
  input  var  svm_pkg::voice_t shift_in,
  input  wire logic            wr,
  input  var  svm_pkg::voice_t wr_val,
  output svm_pkg::voice_t      cur
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cur <= '0;
    end else if (wr) begin
      cur <= wr_val;
    end else if (shift) begin
      cur <= shift_in;
    end
  end

endmodule
`default_nettype wire

@@ design/svm_sample_ram.sv @@
// Sample word memory with one write port and one registered read port.
`default_nettype none
module svm_sample_ram (
  input  wire logic                            clk,
  input  wire logic                            we,
  input  wire logic [svm_pkg::ADDR_W-1:0]      waddr,
  input  wire logic [svm_pkg::SAMPLE_BITS-1:0] wdata,
  input  wire logic [svm_pkg::ADDR_W-1:0]      raddr,
  output logic [svm_pkg::SAMPLE_BITS-1:0]      rdata
);

  logic [svm_pkg::SAMPLE_BITS-1:0] mem [svm_pkg::SAMPLE_WORDS];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

@@ design/sample_voice_mixer_unit.sv @@
// Top level of the sample voice mixer: command decode, voice chain and mix datapath.
//
// Channel   | Direction | Signals                                         | Handshake
// command   | in        | command, sound_index, word_address, word_value, | start, busy
//           |           | extent_length, music_sample                     |
// result    | out       | result_kind, mixed_sample, sound_playing        | done (one-cycle strobe)
// config    | in/out    | psel, penable, pwrite, paddr, pwdata, prdata    | pready (always high)
//
// A query answer appears on the cycle after it is accepted. A tick beat steps
// through the gain products (ST_GAIN, ST_BOOST), the voice chain rotating past
// the shared multiply/accumulate unit (ST_VOICE), the pipeline drain (ST_DRAIN)
// and a rounding state (ST_DONE). The voices are taken in turn so that they share
// the single sample memory read port.
// Reset is synchronous and clears registers, sound table and voices;
// the sample memory is not cleared. The receiver cannot stall: done lasts one cycle.
`default_nettype none
module sample_voice_mixer_unit #(
  parameter int VOICE_COUNT = svm_pkg::DEF_VOICES
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [2:0]  command,
  input  wire logic [4:0]  sound_index,
  input  wire logic [15:0] word_address,
  input  wire logic signed [15:0] word_value,
  input  wire logic [16:0] extent_length,
  input  wire logic signed [15:0] music_sample,
  output logic             done,
  output logic             result_kind,
  output logic signed [15:0] mixed_sample,
  output logic             sound_playing,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [4:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  localparam int VW    = (VOICE_COUNT > 1) ? $clog2(VOICE_COUNT) : 1;
  localparam int CW    = $clog2(VOICE_COUNT + 1);
  localparam int PROD_W = svm_pkg::SAMPLE_BITS + svm_pkg::GAIN_W + 1;
  localparam int ACC_W = PROD_W + CW + 1;

  // Configuration registers.
  logic [15:0] vol_master, vol_effect, vol_music, boost_gain;
  logic [4:0]  boosted_sound;
  logic [5:0]  sounds_in_use;
  logic        cfg_wr;
  logic [15:0] cfg_vol;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;
  // Volumes above unity are stored as unity.
  assign cfg_vol = (pwdata[15:0] > svm_pkg::UNITY_Q15) ? svm_pkg::UNITY_Q15 : pwdata[15:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      vol_master    <= 16'd32768;
      vol_effect    <= 16'd32768;
      vol_music     <= 16'd26214;
      boosted_sound <= 5'd10;
      boost_gain    <= 16'd16384;
      sounds_in_use <= 6'd26;
    end else if (cfg_wr) begin
      case (svm_pkg::reg_idx_t'(paddr[4:2]))
        svm_pkg::REG_MASTER: vol_master    <= cfg_vol;
        svm_pkg::REG_EFFECT: vol_effect    <= cfg_vol;
        svm_pkg::REG_MUSIC:  vol_music     <= cfg_vol;
        svm_pkg::REG_BSOUND: boosted_sound <= pwdata[4:0];
        svm_pkg::REG_BGAIN:  boost_gain    <= pwdata[15:0];
        svm_pkg::REG_INUSE:  sounds_in_use <= pwdata[5:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (svm_pkg::reg_idx_t'(paddr[4:2]))
      svm_pkg::REG_MASTER: prdata = {16'd0, vol_master};
      svm_pkg::REG_EFFECT: prdata = {16'd0, vol_effect};
      svm_pkg::REG_MUSIC:  prdata = {16'd0, vol_music};
      svm_pkg::REG_BSOUND: prdata = {27'd0, boosted_sound};
      svm_pkg::REG_BGAIN:  prdata = {16'd0, boost_gain};
      svm_pkg::REG_INUSE:  prdata = {26'd0, sounds_in_use};
      default:             prdata = 32'd0;
    endcase
  end

  // Control state.
  svm_pkg::state_t state, state_next;
  svm_pkg::ctrl_t  ctrl;
  logic [CW-1:0]   vcnt;
  logic            drain;
  logic            accept;
  svm_pkg::cmd_t   cmd;

  assign accept = start && !busy;
  assign cmd    = svm_pkg::cmd_t'(command);
  assign busy   = ctrl.busy;

  always_comb begin
    state_next = state;
    case (state)
      svm_pkg::ST_IDLE:  if (accept && cmd == svm_pkg::CMD_TICK) state_next = svm_pkg::ST_GAIN;
      svm_pkg::ST_GAIN:  state_next = svm_pkg::ST_BOOST;
      svm_pkg::ST_BOOST: state_next = svm_pkg::ST_VOICE;
      svm_pkg::ST_VOICE: if (vcnt == CW'(VOICE_COUNT - 1)) state_next = svm_pkg::ST_DRAIN;
      svm_pkg::ST_DRAIN: if (drain) state_next = svm_pkg::ST_DONE;
      svm_pkg::ST_DONE:  state_next = svm_pkg::ST_IDLE;
      default:           state_next = svm_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    ctrl.busy  = (state != svm_pkg::ST_IDLE);
    ctrl.shift = (state == svm_pkg::ST_VOICE);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= svm_pkg::ST_IDLE;
      vcnt  <= '0;
      drain <= 1'b0;
    end else begin
      state <= state_next;
      vcnt  <= (state == svm_pkg::ST_VOICE) ? vcnt + CW'(1) : '0;
      drain <= (state == svm_pkg::ST_DRAIN) ? !drain : 1'b0;
    end
  end

  // Sound table.
  logic [15:0] sound_start  [svm_pkg::SOUND_SLOTS];
  logic [16:0] sound_length [svm_pkg::SOUND_SLOTS];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < svm_pkg::SOUND_SLOTS; i++) begin
        sound_start[i]  <= '0;
        sound_length[i] <= '0;
      end
    end else if (accept && cmd == svm_pkg::CMD_EXTENT) begin
      sound_start[sound_index]  <= word_address;
      sound_length[sound_index] <= extent_length;
    end
  end

  // Voice chain: during a tick it rotates one place per cycle, the head voice
  // passing through the update logic and re-entering at the tail.
  svm_pkg::voice_t cur  [VOICE_COUNT];
  svm_pkg::voice_t sin  [VOICE_COUNT];
  logic [VOICE_COUNT-1:0] wr_en, free_v, match_v;
  svm_pkg::voice_t head, head_next, trig_val;
  logic [VW-1:0]   pick;
  logic            slot_ok, trig_fire;

  assign slot_ok   = {1'b0, sound_index} < sounds_in_use;
  assign trig_fire = accept && cmd == svm_pkg::CMD_TRIG && slot_ok;
  assign trig_val  = '{active: 1'b1, sound: sound_index, pos: '0};

  always_comb begin
    pick = '0;
    for (int i = VOICE_COUNT - 1; i >= 0; i--) begin
      if (free_v[i]) pick = VW'(i);
    end
  end

  genvar g;
  generate
    for (g = 0; g < VOICE_COUNT; g++) begin : g_cell
      assign free_v[g]  = !cur[g].active;
      assign match_v[g] = cur[g].active && cur[g].sound == sound_index;
      assign wr_en[g]   = trig_fire && pick == VW'(g);
      if (g == VOICE_COUNT - 1) begin : g_tail
        assign sin[g] = head_next;
      end else begin : g_mid
        assign sin[g] = cur[g+1];
      end
      svm_voice_cell u_cell (
        .clk      (clk),
        .rst      (rst),
        .shift    (ctrl.shift),
        .shift_in (sin[g]),
        .wr       (wr_en[g]),
        .wr_val   (trig_val),
        .cur      (cur[g])
      );
    end
  endgenerate

  assign head = cur[0];

  // Head voice update and sample fetch.
  logic [16:0] h_len;
  logic [15:0] h_start;
  logic [16:0] h_pos1;
  logic        h_play;
  logic [15:0] rd_addr;

  assign h_len   = sound_length[head.sound];
  assign h_start = sound_start[head.sound];
  assign h_play  = head.active && head.pos < h_len;
  assign h_pos1  = head.pos + 17'd1;
  assign rd_addr = h_start + head.pos[15:0];

  always_comb begin
    head_next = head;
    if (head.active) begin
      if (!h_play || h_pos1 >= h_len) begin
        head_next = '0;
      end else begin
        head_next.pos = h_pos1;
      end
    end
  end

  logic [15:0] ram_q;
  svm_sample_ram u_ram (
    .clk   (clk),
    .we    (accept && cmd == svm_pkg::CMD_LOAD),
    .waddr (word_address),
    .wdata (word_value),
    .raddr (rd_addr),
    .rdata (ram_q)
  );

  // Gains and multiply/accumulate pipeline.
  logic [15:0] effect_g, music_g;
  logic [svm_pkg::GAIN_W-1:0] boost_g, p1_gain;
  logic signed [15:0] music_q;
  logic        p1_valid, p2_valid;
  logic signed [PROD_W-1:0] p2_prod;
  logic signed [ACC_W-1:0]  acc, acc_rnd, q;
  logic [31:0] eg_prod, mg_prod, bg_prod;
  logic signed [32:0] mus_prod;

  assign eg_prod  = 32'(vol_effect) * 32'(vol_master);
  assign mg_prod  = 32'(vol_music) * 32'(vol_master);
  assign bg_prod  = 32'(effect_g) * 32'(boost_gain);
  assign mus_prod = music_q * $signed({1'b0, music_g});

  always_ff @(posedge clk) begin
    if (accept && cmd == svm_pkg::CMD_TICK) music_q <= music_sample;
    if (state == svm_pkg::ST_GAIN) begin
      effect_g <= eg_prod[30:15];
      music_g  <= mg_prod[30:15];
    end
    if (state == svm_pkg::ST_BOOST) boost_g <= bg_prod[31:12];
    p1_gain <= (head.sound == boosted_sound) ? boost_g : svm_pkg::GAIN_W'(effect_g);
    p2_prod <= $signed(ram_q) * $signed({1'b0, p1_gain});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      p1_valid <= 1'b0;
      p2_valid <= 1'b0;
      acc      <= '0;
    end else begin
      p1_valid <= ctrl.shift && h_play;
      p2_valid <= p1_valid;
      if (state == svm_pkg::ST_BOOST) begin
        acc <= ACC_W'(mus_prod);
      end else if (p2_valid) begin
        acc <= acc + ACC_W'(p2_prod);
      end
    end
  end

  // Round half up at 2^-15, then saturate.
  assign acc_rnd = acc + ACC_W'(16384);
  assign q       = acc_rnd >>> 15;

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= (state == svm_pkg::ST_DONE) || (accept && cmd == svm_pkg::CMD_QUERY);
    end
  end

  always_ff @(posedge clk) begin
    if (state == svm_pkg::ST_DONE) begin
      result_kind   <= 1'b0;
      sound_playing <= 1'b0;
      if (q > ACC_W'(32767)) mixed_sample <= 16'sd32767;
      else if (q < -ACC_W'(32768)) mixed_sample <= -16'sd32768;
      else mixed_sample <= q[15:0];
    end else begin
      result_kind   <= 1'b1;
      mixed_sample  <= '0;
      sound_playing <= slot_ok && (|match_v);
    end
  end

  a_done_idle: assert property (@(posedge clk) disable iff (rst) done |-> !busy)
    else $error("result strobe while busy");
  a_tick_src: assert property (@(posedge clk) disable iff (rst)
      (done && !result_kind) |-> $past(state) == svm_pkg::ST_DONE)
    else $error("mix result without finished tick");
  a_vcnt: assert property (@(posedge clk) disable iff (rst)
      state == svm_pkg::ST_VOICE |-> vcnt < CW'(VOICE_COUNT))
    else $error("voice counter overrun");
  a_no_fetch_idle: assert property (@(posedge clk) disable iff (rst)
      state == svm_pkg::ST_IDLE |=> !p1_valid)
    else $error("fetch outside tick");

endmodule
`default_nettype wire
